>>> rtl/core/skl_pkg.sv
// shared types, codes and sizes for the sorted keyed list
// no dependencies
package skl_pkg;

  localparam int CAPACITY    = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int DATA_W      = 32;

  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

  localparam int RESQ_DEPTH  = 4;
  localparam int RESQ_PTR_W  = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W  = $clog2(RESQ_DEPTH + 1);

  typedef logic [1:0] opcode_t;
  typedef logic [1:0] status_t;

  localparam opcode_t OP_INSERT = 2'd0;
  localparam opcode_t OP_DELETE = 2'd1;
  localparam opcode_t OP_SHOW   = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOTFOUND = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_EMPTY    = 2'd3;

  typedef struct packed {
    opcode_t                  op;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t                  status;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } res_t;

endpackage

>>> rtl/core/skl_front.sv
// front end: accepts input words, drops unused opcodes, queues commands
// depends on skl_pkg
module skl_front import skl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [1:0]               in_opcode,
  input  logic signed [DATA_W-1:0] in_key,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     cmd_valid,
  output cmd_t                     cmd,
  input  logic                     cmd_pop
);

  cmd_t                  mem_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  accept;
  logic                  enq;
  logic                  deq;
  logic                  known_op;

  assign in_full   = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign accept    = in_push && !in_full;
  assign known_op  = (in_opcode == OP_INSERT) || (in_opcode == OP_DELETE) ||
                     (in_opcode == OP_SHOW);
  assign enq       = accept && known_op;
  assign cmd_valid = (cnt_r != '0);
  assign deq       = cmd_pop && cmd_valid;
  assign cmd       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = enq ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = deq ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({enq, deq})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem_r[wr_ptr_r] <= '{op: in_opcode, key: in_key, value: in_value};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/skl_core.sv
// back end: row of key/value cells with parallel compare and shift, show sequencer
// depends on skl_pkg
module skl_core import skl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_full,
  output logic res_push,
  output res_t res
);

  typedef enum logic [1:0] {S_IDLE, S_APPLY, S_SHOW} state_t;

  state_t                   state_r, state_nxt;
  cmd_t                     cmd_r, cmd_nxt;
  logic [CAPACITY-1:0]      ge_r, ge_nxt, ge_c;
  logic [CAPACITY-1:0]      hit_r, hit_nxt, hit_c;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic signed [DATA_W-1:0] key_r [CAPACITY];
  logic signed [DATA_W-1:0] key_nxt [CAPACITY];
  logic signed [DATA_W-1:0] val_r [CAPACITY];
  logic signed [DATA_W-1:0] val_nxt [CAPACITY];

  // compare the queued key against every cell
  always_comb begin
    logic acc;
    logic in_list;
    acc = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      in_list  = (CNT_W'(i) < cnt_r);
      ge_c[i]  = !in_list || !(key_r[i] < cmd.key);
      acc      = acc | (in_list && (key_r[i] == cmd.key));
      hit_c[i] = acc;
    end
  end

  always_comb begin
    logic is_last;
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    ge_nxt    = ge_r;
    hit_nxt   = hit_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    res       = '{status: ST_OK, key: '0, value: '0, last: 1'b1};
    is_last   = (CNT_W'(idx_r) + CNT_W'(1) == cnt_r);
    unique case (state_r)
      S_IDLE: begin
        idx_nxt = '0;
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd;
          ge_nxt    = ge_c;
          hit_nxt   = hit_c;
          state_nxt = (cmd.op == OP_SHOW) ? S_SHOW : S_APPLY;
        end
      end
      S_APPLY: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
          if (cmd_r.op == OP_INSERT) begin
            if (cnt_r == CNT_W'(CAPACITY)) begin
              res.status = ST_FULL;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
              if (ge_r[0]) begin
                key_nxt[0] = cmd_r.key;
                val_nxt[0] = cmd_r.value;
              end
              for (int i = 1; i < CAPACITY; i++) begin
                if (ge_r[i] && !ge_r[i-1]) begin
                  key_nxt[i] = cmd_r.key;
                  val_nxt[i] = cmd_r.value;
                end else if (ge_r[i]) begin
                  key_nxt[i] = key_r[i-1];
                  val_nxt[i] = val_r[i-1];
                end
              end
            end
          end else begin
            if (hit_r[CAPACITY-1]) begin
              cnt_nxt = cnt_r - 1'b1;
              for (int i = 0; i < CAPACITY - 1; i++) begin
                if (hit_r[i]) begin
                  key_nxt[i] = key_r[i+1];
                  val_nxt[i] = val_r[i+1];
                end
              end
            end else begin
              res.status = ST_NOTFOUND;
            end
          end
        end
      end
      S_SHOW: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (cnt_r == '0) begin
            res.status = ST_EMPTY;
            state_nxt  = S_IDLE;
          end else begin
            res.key   = key_r[idx_r];
            res.value = val_r[idx_r];
            res.last  = is_last;
            idx_nxt   = idx_r + 1'b1;
            if (is_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    ge_r  <= ge_nxt;
    hit_r <= hit_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

>>> rtl/core/skl_resq.sv
// result queue between the cell row and the output ports
// depends on skl_pkg
module skl_resq import skl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     res_push,
  input  res_t                     res,
  output logic                     res_full,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_key,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_last
);

  res_t                  mem_r [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RESQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RESQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  enq;
  logic                  deq;
  res_t                  head;

  assign res_full  = (cnt_r == RESQ_CNT_W'(RESQ_DEPTH));
  assign out_empty = (cnt_r == '0);
  assign enq       = res_push && !res_full;
  assign deq       = out_pop && !out_empty;

  assign head       = mem_r[rd_ptr_r];
  assign out_status = head.status;
  assign out_key    = head.key;
  assign out_value  = head.value;
  assign out_last   = head.last;

  always_comb begin
    wr_ptr_nxt = enq ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = deq ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({enq, deq})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      mem_r[wr_ptr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/sorted_keyed_list.sv
// sorted keyed list: up to 32 (key, value) entries kept in ascending signed key order
// input words: opcode insert, delete or show, with key and value; push / full
// result words: status, out_key, out_value, out_last; empty / pop, oldest word first
// an insert into a full list answers list full; a delete with no match answers not found
// a show gives one word per entry, last marked, or one list-empty word
// opcode three is dropped with no result
// a result goes through the command queue, the registered compare and the result
// queue before it shows on the ports; insert and delete each take a compare and a shift
// step of the cell row; a show gives one word per cycle from the cell row while the
// result queue has room; the cell row takes no new command until the last is done
// a two-word command queue and a four-word result queue keep the sides apart:
// input words are still taken while results wait, until the command queue fills
// when pop stays low the result queue fills and the cell row waits; nothing is lost
// reset (rst_n low, synchronous) empties the list and both queues
// depends on skl_pkg, skl_front, skl_core, skl_resq
module sorted_keyed_list import skl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [1:0]               in_opcode,
  input  logic signed [DATA_W-1:0] in_key,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_key,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     out_last
);

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic res_full;
  logic res_push;
  res_t res;

  skl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_opcode (in_opcode),
    .in_key    (in_key),
    .in_value  (in_value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  skl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  skl_resq u_resq (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_status (out_status),
    .out_key    (out_key),
    .out_value  (out_value),
    .out_last   (out_last)
  );

endmodule

>>> rtl/core/skl_checker.sv
// port-level checks for the sorted keyed list, bound to the top level
// depends on skl_pkg and sorted_keyed_list
module skl_checker import skl_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_push,
  input logic                     in_full,
  input logic                     out_empty,
  input logic                     out_pop,
  input logic [1:0]               out_status,
  input logic signed [DATA_W-1:0] out_key,
  input logic signed [DATA_W-1:0] out_value,
  input logic                     out_last
);

  // waiting result word holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_status) && $stable(out_key) &&
      $stable(out_value) && $stable(out_last))
    else $error("result word changed while waiting");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // error and empty answers carry no entry and end their input
  a_fail_word: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_status != ST_OK) |-> out_last && (out_key == '0) && (out_value == '0))
    else $error("non-ok result word malformed");

  a_full_rise: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_push && !in_full) |=> !$rose(in_full))
    else $error("full rose without an accepted word");

endmodule

bind sorted_keyed_list skl_checker u_skl_checker (.*);

>>> tb/tb_top.sv
// self-checking bench for sorted_keyed_list: a directed table, then random insert,
// delete and show traffic with random gaps on both queue sides, checked against a shadow list
// depends on skl_pkg and the sorted_keyed_list rtl
module tb_top;
  import skl_pkg::*;

  localparam opcode_t OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 480;
  localparam int PHASE_ITEMS = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER = 200;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PRINT_LIMIT = 50;
  localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    opcode_t                  op;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
    logic                     typed;
    status_t                  status;
  } stim_row_t;

  localparam int N_ROWS = 22;
  stim_row_t directed_rows [N_ROWS] = '{
    '{OP_SHOW,   32'sd0,       32'sd0,          1'b1, ST_EMPTY},
    '{OP_DELETE, 32'sd5,       32'sd0,          1'b1, ST_NOTFOUND},
    '{OP_UNUSED, KEY_MAX,      KEY_MIN,         1'b0, ST_OK},
    '{OP_INSERT, KEY_MIN,      KEY_MAX,         1'b1, ST_OK},
    '{OP_INSERT, KEY_MAX,      KEY_MIN,         1'b1, ST_OK},
    '{OP_INSERT, 32'sd0,       32'sd1,          1'b1, ST_OK},
    '{OP_INSERT, 32'sd0,       32'sd2,          1'b1, ST_OK},
    '{OP_INSERT, -32'sd1,      -32'sd1,         1'b1, ST_OK},
    '{OP_SHOW,   32'sd0,       32'sd0,          1'b0, ST_OK},
    '{OP_DELETE, 32'sd0,       32'sd0,          1'b1, ST_OK},
    '{OP_DELETE, 32'sd7,       32'sd0,          1'b1, ST_NOTFOUND},
    '{OP_SHOW,   32'sd0,       32'sd0,          1'b0, ST_OK},
    '{OP_DELETE, KEY_MAX,      32'sd0,          1'b1, ST_OK},
    '{OP_DELETE, KEY_MIN,      32'sd0,          1'b1, ST_OK},
    '{OP_INSERT, 32'sd1,       32'shaaaa_aaaa,  1'b1, ST_OK},
    '{OP_INSERT, 32'sd1,       32'sh5555_5555,  1'b1, ST_OK},
    '{OP_SHOW,   32'shffff_0000, 32'sh0000_ffff, 1'b0, ST_OK},
    '{OP_UNUSED, 32'sh5555_5555, 32'shaaaa_aaaa, 1'b0, ST_OK},
    '{OP_DELETE, 32'sd1,       32'sd0,          1'b1, ST_OK},
    '{OP_DELETE, 32'sd1,       32'sd0,          1'b1, ST_OK},
    '{OP_DELETE, 32'sd1,       32'sd0,          1'b1, ST_NOTFOUND},
    '{OP_SHOW,   32'sd0,       32'sd0,          1'b0, ST_OK}
  };

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_push = 1'b0;
  logic                     in_full;
  logic [1:0]               in_opcode = OP_INSERT;
  logic signed [DATA_W-1:0] in_key = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_empty;
  logic                     out_pop = 1'b0;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_key;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;

  logic signed [DATA_W-1:0] shadow_key [CAPACITY];
  logic signed [DATA_W-1:0] shadow_value [CAPACITY];
  int   shadow_len = 0;
  res_t pending_words [$];
  int   error_count = 0;
  int   words_popped = 0;
  int   cycle_count = 0;

  sorted_keyed_list DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_opcode (in_opcode),
    .in_key    (in_key),
    .in_value  (in_value),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_status(out_status),
    .out_key   (out_key),
    .out_value (out_value),
    .out_last  (out_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  task automatic report(string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic res_t status_word(status_t st);
    res_t w;
    w.status = st;
    w.key = '0;
    w.value = '0;
    w.last = 1'b1;
    return w;
  endfunction

  // update the shadow list for one accepted word and queue its results
  function automatic void list_apply(opcode_t op, logic signed [DATA_W-1:0] k,
                                     logic signed [DATA_W-1:0] v, logic typed, status_t st);
    res_t produced [$];
    res_t w;
    int   pos;
    case (op)
      OP_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          produced.push_back(status_word(ST_FULL));
        end else begin
          pos = 0;
          while (pos < shadow_len && shadow_key[pos] < k) pos++;
          for (int i = shadow_len; i > pos; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_value[i] = shadow_value[i-1];
          end
          shadow_key[pos] = k;
          shadow_value[pos] = v;
          shadow_len++;
          produced.push_back(status_word(ST_OK));
        end
      end
      OP_DELETE: begin
        pos = 0;
        while (pos < shadow_len && shadow_key[pos] !== k) pos++;
        if (pos >= shadow_len) begin
          produced.push_back(status_word(ST_NOTFOUND));
        end else begin
          for (int i = pos; i < shadow_len - 1; i++) begin
            shadow_key[i] = shadow_key[i+1];
            shadow_value[i] = shadow_value[i+1];
          end
          shadow_len--;
          produced.push_back(status_word(ST_OK));
        end
      end
      OP_SHOW: begin
        if (shadow_len == 0) begin
          produced.push_back(status_word(ST_EMPTY));
        end else begin
          for (int i = 0; i < shadow_len; i++) begin
            w.status = ST_OK;
            w.key = shadow_key[i];
            w.value = shadow_value[i];
            w.last = (i == shadow_len - 1);
            produced.push_back(w);
          end
        end
      end
      default: ;
    endcase
    if (typed) begin
      produced.delete();
      produced.push_back(status_word(st));
    end
    foreach (produced[i]) pending_words.push_back(produced[i]);
  endfunction

  task automatic check_word(status_t st, logic signed [DATA_W-1:0] k,
                            logic signed [DATA_W-1:0] v, logic lst);
    res_t want;
    if (pending_words.size() == 0) begin
      report($sformatf("word with none expected: status %0d key %0d value %0d last %0b",
                       st, k, v, lst));
    end else begin
      want = pending_words.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, expected %0d", st, want.status));
      if (k !== want.key)
        report($sformatf("out_key %0d, expected %0d", k, want.key));
      if (v !== want.value)
        report($sformatf("out_value %0d, expected %0d", v, want.value));
      if (lst !== want.last)
        report($sformatf("out_last %0b, expected %0b", lst, want.last));
    end
  endtask

  task automatic send_word(opcode_t op, logic signed [DATA_W-1:0] k,
                           logic signed [DATA_W-1:0] v, logic typed, status_t st, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_opcode <= op;
    in_key <= k;
    in_value <= v;
    @(posedge clk);
    while (in_full) @(posedge clk);
    list_apply(op, k, v, typed, st);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_key();
    case ($urandom_range(0, 7))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2, 3: return $urandom;
      default: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return KEY_MIN;
      1: return KEY_MAX;
      default: return $urandom;
    endcase
  endfunction

  initial begin : word_source
    int                       counted;
    int                       phase;
    int                       roll;
    opcode_t                  op;
    logic signed [DATA_W-1:0] k;
    logic signed [DATA_W-1:0] v;
    bit                       no_gap;
    counted = 0;
    phase = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < N_ROWS; r++) begin
      send_word(directed_rows[r].op, directed_rows[r].key, directed_rows[r].value,
                directed_rows[r].typed, directed_rows[r].status, 1'b0);
    end
    // phases cycle through fill, mixed and drain traffic
    while (counted < ITEM_TARGET) begin
      no_gap = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < PHASE_ITEMS && counted < ITEM_TARGET; j++) begin
        roll = $urandom_range(0, 99);
        case (phase % 3)
          0: op = roll < 85 ? OP_INSERT : roll < 95 ? OP_SHOW : roll < 98 ? OP_DELETE : OP_UNUSED;
          1: op = roll < 40 ? OP_INSERT : roll < 80 ? OP_DELETE : roll < 95 ? OP_SHOW : OP_UNUSED;
          default: op = roll < 80 ? OP_DELETE : roll < 90 ? OP_SHOW :
                        roll < 97 ? OP_INSERT : OP_UNUSED;
        endcase
        k = pick_key();
        v = pick_value();
        if (op == OP_DELETE && shadow_len > 0 && $urandom_range(0, 3) != 0)
          k = shadow_key[$urandom_range(0, shadow_len - 1)];
        send_word(op, k, v, 1'b0, ST_OK, no_gap);
        if (op != OP_UNUSED) counted++;
      end
      phase++;
    end
    in_push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin : word_sink
    int  gap;
    bit  no_gap;
    bit  held;
    no_gap = 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) no_gap = !no_gap;
      gap = no_gap ? 0 : $urandom_range(0, 11);
      // one long hold-off so both queues fill and the input stalls
      if (!held && words_popped >= HOLD_AFTER) begin
        held = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      words_popped++;
      check_word(out_status, out_key, out_value, out_last);
    end
  end

endmodule
